/* hw/rtl/tkcl_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkcl_pkg: shared types and constants of the top-k candidate list
// Item formats, controller commands and status, operation codes and sizes.
// ---------------------------------------------------------------------------
package tkcl_pkg;

   localparam int VID_W     = 20;
   localparam int QUAL_W    = 32;
   localparam int IDX_W     = 6;
   localparam int COUNT_W   = 7;
   localparam int ENTRY_W   = VID_W + QUAL_W;

   localparam int TKCL_MAX_DEPTH = 64;

   localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } tkcl_op_type;

   typedef enum logic [1:0] {
      FIN_NONE   = 2'd0,
      FIN_ACCEPT = 2'd1,
      FIN_READ   = 2'd2
   } tkcl_fin_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_REQ,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_SHIFT_REQ,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_READ_CAP
   } tkcl_state_type;

   typedef struct packed {
      logic [1:0]               operation;
      logic [VID_W-1:0]         vertex_id;
      logic signed [QUAL_W-1:0] quality;
      logic [IDX_W-1:0]         read_index;
   } tkcl_req_type;

   typedef struct packed {
      logic                     accepted;
      logic [COUNT_W-1:0]       entry_count;
      logic                     read_valid;
      logic [VID_W-1:0]         read_vertex;
      logic signed [QUAL_W-1:0] read_quality;
   } tkcl_rsp_type;

   typedef struct packed {
      logic         load;
      logic         ptr_zero;
      logic         ptr_inc;
      logic         ptr_top;
      logic         ptr_dec;
      logic         set_pos;
      logic         scan_rd;
      logic         shift_rd;
      logic         shift_wr;
      logic         place;
      logic         item_rd;
      logic         clear_count;
      logic         bump_count;
      logic         finish;
      tkcl_fin_type fin_kind;
   } tkcl_cmd_type;

   typedef struct packed {
      tkcl_op_type op;
      logic        scan_end;
      logic        dup_hit;
      logic        q_gt;
      logic        pos_in;
      logic        shift_end;
   } tkcl_stat_type;

endpackage

/* hw/rtl/top_k_candidate_list.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_k_candidate_list: sorted list of the best vertex candidates
// Keeps (vertex id, quality) pairs in descending quality order, rejects
// duplicate ids at or ahead of the insertion point, and serves clear and read.
// ---------------------------------------------------------------------------
//
//   channel   ports                          handshake
//   -------   -----------------------------  ------------------------------
//   request   start, busy, req_data          taken when start and !busy
//   result    rsp_valid, rsp_data            one-cycle strobe, no stall
//   config    csr_wr_en, csr_wr_data         written when csr_wr_en
//
// Clear and no-op finish from dispatch; read finishes once the RAM data is back.
// Insert walks the list comparing entries, then either moves the entries below
// the insertion point down and places the item, or accepts it without storing
// it when it falls past the limit; a duplicate ends the insert unaccepted.
// Reset is synchronous: the list is empty and the limit is 64.
// The receiver cannot hold results off; busy holds off new items.
// ---------------------------------------------------------------------------
module top_k_candidate_list
   import tkcl_pkg::*;
#(
   parameter int MAX_DEPTH = TKCL_MAX_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tkcl_req_type       req_data,
   output logic               rsp_valid,
   output tkcl_rsp_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   tkcl_cmd_type  cmd;
   tkcl_stat_type stat;

   tkcl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tkcl_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

/* hw/rtl/tkcl_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkcl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tkcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tkcl_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkcl_ctrl: operation sequencer of the candidate list
// Walks the list for an insert, moves entries down, places the item, and
// issues the result strobe for every operation.
// ---------------------------------------------------------------------------
module tkcl_ctrl
   import tkcl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  tkcl_stat_type stat,
   output tkcl_cmd_type  cmd
);

   tkcl_state_type state_ff;
   tkcl_state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.fin_kind = FIN_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.op)
               OP_CLEAR: begin
                  cmd.clear_count = 1'b1;
                  cmd.finish      = 1'b1;
                  state_in        = ST_IDLE;
               end
               OP_INSERT: begin
                  cmd.ptr_zero = 1'b1;
                  state_in     = ST_SCAN_REQ;
               end
               OP_READ: begin
                  cmd.item_rd = 1'b1;
                  state_in    = ST_READ_CAP;
               end
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_SCAN_REQ: begin
            if (stat.scan_end) begin
               cmd.set_pos = 1'b1;
               state_in    = ST_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (stat.dup_hit) begin
               // drop the item as a duplicate
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (stat.q_gt) begin
               cmd.set_pos = 1'b1;
               state_in    = ST_DECIDE;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = ST_SCAN_REQ;
            end
         end
         ST_DECIDE: begin
            if (stat.pos_in) begin
               cmd.ptr_top = 1'b1;
               state_in    = ST_SHIFT_REQ;
            end else begin
               // item falls off the end but still counts
               cmd.bump_count = 1'b1;
               cmd.finish     = 1'b1;
               cmd.fin_kind   = FIN_ACCEPT;
               state_in       = ST_IDLE;
            end
         end
         ST_SHIFT_REQ: begin
            if (stat.shift_end) begin
               state_in = ST_PLACE;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.ptr_dec  = 1'b1;
            state_in     = ST_SHIFT_REQ;
         end
         ST_PLACE: begin
            cmd.place      = 1'b1;
            cmd.bump_count = 1'b1;
            cmd.finish     = 1'b1;
            cmd.fin_kind   = FIN_ACCEPT;
            state_in       = ST_IDLE;
         end
         ST_READ_CAP: begin
            cmd.finish   = 1'b1;
            cmd.fin_kind = FIN_READ;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/tkcl_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tkcl_datapath: entry store, pointers, count and result register
// Holds the sorted entries in RAM and carries out the sequencer's commands.
// ---------------------------------------------------------------------------
module tkcl_datapath
   import tkcl_pkg::*;
#(
   parameter int MAX_DEPTH = TKCL_MAX_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  tkcl_req_type       req_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  tkcl_cmd_type       cmd,
   output tkcl_stat_type      stat,
   output logic               rsp_valid,
   output tkcl_rsp_type       rsp_data
);

   localparam int AW = $clog2(MAX_DEPTH);

   // request holding registers
   logic [1:0]               op_ff;
   logic [VID_W-1:0]         vid_ff;
   logic signed [QUAL_W-1:0] q_ff;
   logic [IDX_W-1:0]         idx_ff;

   // control state
   logic [COUNT_W-1:0] cap_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;

   // walk pointers
   logic [COUNT_W-1:0] ptr_ff;
   logic [COUNT_W-1:0] ptr_in;
   logic [COUNT_W-1:0] pos_ff;

   logic [COUNT_W-1:0] lim;
   logic [COUNT_W-1:0] top;

   tkcl_rsp_type rsp_ff;
   tkcl_rsp_type rsp_in;

   // memory ports
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [VID_W-1:0]         rd_vid;
   logic signed [QUAL_W-1:0] rd_q;
   logic                     read_ok;

   tkcl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_vid = rd_data[ENTRY_W-1:QUAL_W];
   assign rd_q   = $signed(rd_data[QUAL_W-1:0]);

   // clamp the limit to 1 .. MAX_DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         lim = COUNT_W'(1);
      end else if (int'(cap_ff) > MAX_DEPTH) begin
         lim = COUNT_W'(MAX_DEPTH);
      end else begin
         lim = cap_ff;
      end
   end

   // last slot that a shift fills
   assign top = (count_ff < lim) ? count_ff : (lim - COUNT_W'(1));

   // drive memory ports
   assign wr_en   = cmd.shift_wr | cmd.place;
   assign wr_addr = cmd.place ? AW'(pos_ff) : AW'(ptr_ff);
   assign wr_data = cmd.place ? {vid_ff, q_ff} : rd_data;
   assign rd_en   = cmd.scan_rd | cmd.shift_rd | cmd.item_rd;

   always_comb begin
      if (cmd.item_rd) begin
         rd_addr = AW'(idx_ff);
      end else if (cmd.shift_rd) begin
         rd_addr = AW'(ptr_ff - COUNT_W'(1));
      end else begin
         rd_addr = AW'(ptr_ff);
      end
   end

   // status back to the sequencer
   assign stat.op        = tkcl_op_type'(op_ff);
   assign stat.scan_end  = (ptr_ff == count_ff);
   assign stat.dup_hit   = (rd_vid == vid_ff);
   assign stat.q_gt      = (q_ff > rd_q);
   assign stat.pos_in    = (pos_ff < lim);
   assign stat.shift_end = (ptr_ff == pos_ff);

   // advance pointer
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_zero) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + COUNT_W'(1);
      end else if (cmd.ptr_top) begin
         ptr_in = top;
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - COUNT_W'(1);
      end
   end

   // update entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.bump_count) begin
         count_in = (count_ff >= lim) ? lim : (count_ff + COUNT_W'(1));
      end
   end

   // build the result item
   assign read_ok = ({1'b0, idx_ff} < count_ff);

   always_comb begin
      rsp_in             = '0;
      rsp_in.entry_count = count_in;
      case (cmd.fin_kind)
         FIN_ACCEPT: begin
            rsp_in.accepted = 1'b1;
         end
         FIN_READ: begin
            if (read_ok) begin
               rsp_in.read_valid   = 1'b1;
               rsp_in.read_vertex  = rd_vid;
               rsp_in.read_quality = rd_q;
            end
         end
         default: begin
            rsp_in.accepted = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.operation;
         vid_ff <= req_data.vertex_id;
         q_ff   <= req_data.quality;
         idx_ff <= req_data.read_index;
      end
      if (cmd.set_pos) begin
         pos_ff <= ptr_ff;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
      ptr_ff <= ptr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // an accepted insert never carries read data
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.read_valid))
      else $error("result marks both accept and read");

   // a placed item lands inside the limit
   a_place_in_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> (pos_ff < lim))
      else $error("item placed beyond the limit");

   // a move writes only below the insertion point
   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> (ptr_ff > pos_ff) && $past(cmd.shift_rd))
      else $error("entry move out of order");

   // the count never exceeds the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.bump_count |=> (int'(count_ff) <= MAX_DEPTH))
      else $error("entry count beyond store depth");
`endif

endmodule
